>>> design/mtx_pkg.sv
package mtx_pkg;

  // Offset between the 1904 movie epoch and the Unix epoch, in seconds.
  localparam logic [31:0] EPOCH_SHIFT = 32'd2082844800;

  // Four-character box types, big-endian.
  localparam logic [31:0] KIND_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] KIND_MVHD = 32'h6D766864;

  // Box header is size plus type.
  localparam logic [31:0] HDR_LEN   = 32'd8;
  // Smallest mvhd box that still carries both time fields.
  localparam logic [31:0] MVHD_MIN  = 32'd20;

  // Result kinds.
  localparam logic RES_TIMES = 1'b0;
  localparam logic RES_ERROR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] created;
    logic [31:0] modified;
  } result_t;

endpackage

>>> design/mp4_movie_header_time_extractor.sv
// MP4 movie header time extractor.
// Input channel: in_valid / in_ready with data_byte and start_of_file; one
// file byte per beat, start_of_file set on the first byte of each file.
// Output channel: out_valid / out_ready with result_kind, created_seconds
// and modified_seconds. A beat carries either the mvhd creation and
// modification times converted to Unix seconds, or an error for a box
// whose size is below 8 (parsing then halts until the next start_of_file).
// Throughput: one byte per cycle while no byte waits to produce a second
// result. The byte is registered in the input register; the parser logic
// then updates the box counters and loads the result register, which
// offers the result. Most bytes produce no result.
// Stall: a waiting result holds in the output register; bytes that
// produce no result keep flowing. Only a byte that would produce a second
// result waits in the input register until the first one is taken.
// Reset: rst (synchronous) empties both registers and returns the parser to
// the top-level box header; start_of_file does the same for the parse state.
module mp4_movie_header_time_extractor
  import mtx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] created_seconds,
  output logic [31:0] modified_seconds
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sof;

  logic    emit;
  result_t res;
  logic    advance;

  // a byte moves through the parser unless it carries a result and the
  // output register is still full
  assign advance  = s1_valid && (!out_valid || out_ready || !emit);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_sof  <= start_of_file;
    end
  end

  mtx_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (s1_byte),
    .start_of_file (s1_sof),
    .emit          (emit),
    .result        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_kind      <= res.kind;
      created_seconds  <= res.created;
      modified_seconds <= res.modified;
    end
  end

endmodule

>>> design/mtx_parser.sv
module mtx_parser
  import mtx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       start_of_file,
  output logic       emit,
  output result_t    result
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_MVHD   = 2'd2;

  localparam logic [3:0] OFF_CREATED  = 4'd4;
  localparam logic [3:0] OFF_MODIFIED = 4'd8;
  localparam logic [3:0] OFF_LAST     = 4'd11;
  localparam logic [3:0] OFF_DONE     = 4'd12;

  logic [1:0]  phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [31:0] box_length, box_length_next;
  logic [31:0] box_kind, box_kind_next;
  logic [31:0] box_left, box_left_next;
  logic [31:0] cont_left, cont_left_next;
  logic        in_moov, in_moov_next;
  logic [31:0] created, created_next;
  logic        halted, halted_next;
  logic [3:0]  mvhd_off, mvhd_off_next;

  // current state, with start-of-file applied first
  logic [1:0]  c_phase;
  logic [2:0]  c_count;
  logic [31:0] c_length, c_kind, c_left, c_cont, c_created;
  logic        c_inside, c_halted;
  logic [3:0]  c_off;

  always_comb begin
    c_phase   = start_of_file ? PH_HEADER : phase;
    c_count   = start_of_file ? 3'd0 : hdr_count;
    c_length  = start_of_file ? '0 : box_length;
    c_kind    = start_of_file ? '0 : box_kind;
    c_left    = start_of_file ? '0 : box_left;
    c_cont    = start_of_file ? '0 : cont_left;
    c_inside  = start_of_file ? 1'b0 : in_moov;
    c_created = start_of_file ? '0 : created;
    c_halted  = start_of_file ? 1'b0 : halted;
    c_off     = start_of_file ? 4'd0 : mvhd_off;

    phase_next      = c_phase;
    hdr_count_next  = c_count;
    box_length_next = c_length;
    box_kind_next   = c_kind;
    box_left_next   = c_left;
    cont_left_next  = c_cont;
    in_moov_next    = c_inside;
    created_next    = c_created;
    halted_next     = c_halted;
    mvhd_off_next   = c_off;
    emit            = 1'b0;
    result          = '0;

    if (!c_halted) begin
      if (c_inside) begin
        cont_left_next = c_cont - 32'd1;
      end

      if (c_phase == PH_HEADER) begin
        if (!c_count[2]) begin
          box_length_next = {c_length[23:0], data_byte};
        end else begin
          box_kind_next = {c_kind[23:0], data_byte};
        end
        hdr_count_next = c_count + 3'd1;
        if (c_count == 3'd7) begin
          phase_next = PH_HEADER;
          if (c_length < HDR_LEN) begin
            halted_next   = 1'b1;
            emit          = 1'b1;
            result.kind   = RES_ERROR;
          end else if (!c_inside && box_kind_next == KIND_MOOV) begin
            if (c_length != HDR_LEN) begin
              in_moov_next   = 1'b1;
              cont_left_next = c_length - HDR_LEN;
            end
          end else if (c_inside && box_kind_next == KIND_MVHD && c_length >= MVHD_MIN) begin
            phase_next    = PH_MVHD;
            box_left_next = c_length - HDR_LEN;
            created_next  = '0;
            box_kind_next = '0;
            mvhd_off_next = 4'd0;
          end else if (c_length != HDR_LEN) begin
            phase_next    = PH_SKIP;
            box_left_next = c_length - HDR_LEN;
          end
        end
      end else begin
        if (c_phase == PH_MVHD) begin
          if (c_off >= OFF_CREATED && c_off < OFF_MODIFIED) begin
            created_next = {c_created[23:0], data_byte};
          end else if (c_off >= OFF_MODIFIED && c_off <= OFF_LAST) begin
            box_kind_next = {c_kind[23:0], data_byte};
          end
          if (c_off == OFF_LAST) begin
            emit            = 1'b1;
            result.kind     = RES_TIMES;
            result.created  = c_created - EPOCH_SHIFT;
            result.modified = {c_kind[23:0], data_byte} - EPOCH_SHIFT;
          end
          mvhd_off_next = (c_off == OFF_DONE) ? OFF_DONE : c_off + 4'd1;
        end
        box_left_next = c_left - 32'd1;
        if (c_left == 32'd1) begin
          phase_next = PH_HEADER;
        end
      end

      // moov payload ran out: cut off any child and go back to top level
      if (!halted_next && in_moov_next && cont_left_next == 32'd0) begin
        in_moov_next    = 1'b0;
        phase_next      = PH_HEADER;
        hdr_count_next  = 3'd0;
        box_left_next   = '0;
        box_length_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_count  <= 3'd0;
      box_length <= '0;
      box_kind   <= '0;
      box_left   <= '0;
      cont_left  <= '0;
      in_moov    <= 1'b0;
      created    <= '0;
      halted     <= 1'b0;
      mvhd_off   <= 4'd0;
    end else if (step) begin
      phase      <= phase_next;
      hdr_count  <= hdr_count_next;
      box_length <= box_length_next;
      box_kind   <= box_kind_next;
      box_left   <= box_left_next;
      cont_left  <= cont_left_next;
      in_moov    <= in_moov_next;
      created    <= created_next;
      halted     <= halted_next;
      mvhd_off   <= mvhd_off_next;
    end
  end

endmodule

>>> tb/tb_mp4_movie_header_time_extractor.sv
`timescale 1ns / 1ps

module tb_mp4_movie_header_time_extractor;
  import mtx_pkg::*;

  // Box type used for filler boxes in the stimulus.
  localparam logic [31:0] KIND_FREE = 32'h66726565;

  // Cycles with no beat on either side before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 600;
  // Random file at which the receiver holds off; from it on, HOLD_SPAN files
  // are packed with movie headers and sent without gaps so results pile up.
  localparam int HOLD_FILE   = 4;
  localparam int HOLD_SPAN   = 6;
  localparam int BYTE_GOAL   = 1600;
  localparam int TIMES_GOAL  = 40;

  typedef enum logic [1:0] {WALK_HEADER, WALK_SKIP, WALK_MVHD} walk_phase_e;

  // Directed row: 1..4 bytes of a big-endian word. start_of_file goes on
  // the first byte; a typed result, if any, belongs to the last byte.
  typedef struct packed {
    logic        sof;
    logic [2:0]  nbytes;
    logic [31:0] word;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam int PLAN_ROWS = 33;
  localparam dir_row_t PLAN [PLAN_ROWS] = '{
    // size zero box: error beat, then bytes are ignored until a new file
    '{1'b1, 3'd4, 32'd0,          1'b0, '0},
    '{1'b0, 3'd4, KIND_FREE,      1'b1, '{RES_ERROR, 32'd0, 32'd0}},
    '{1'b0, 3'd4, 32'hFFFFFFFF,   1'b0, '0},
    // moov holding one mvhd; times sit right at the epoch edge
    '{1'b1, 3'd4, 32'd28,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MOOV,      1'b0, '0},
    '{1'b0, 3'd4, 32'd20,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MVHD,      1'b0, '0},
    '{1'b0, 3'd4, 32'hFFFFFFFF,   1'b0, '0},
    '{1'b0, 3'd4, EPOCH_SHIFT,    1'b0, '0},
    '{1'b0, 3'd4, EPOCH_SHIFT - 32'd1, 1'b1, '{RES_TIMES, 32'd0, 32'hFFFFFFFF}},
    // empty top-level box
    '{1'b0, 3'd4, 32'd8,          1'b0, '0},
    '{1'b0, 3'd4, KIND_FREE,      1'b0, '0},
    // mvhd outside moov is just skipped
    '{1'b0, 3'd4, 32'd20,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MVHD,      1'b0, '0},
    '{1'b0, 3'd4, 32'h00000000,   1'b0, '0},
    '{1'b0, 3'd4, 32'hFFFFFFFF,   1'b0, '0},
    '{1'b0, 3'd4, 32'h00000000,   1'b0, '0},
    // empty moov
    '{1'b0, 3'd4, 32'd8,          1'b0, '0},
    '{1'b0, 3'd4, KIND_MOOV,      1'b0, '0},
    // mvhd with an 11-byte payload: too short, no beat
    '{1'b0, 3'd4, 32'd27,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MOOV,      1'b0, '0},
    '{1'b0, 3'd4, 32'd19,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MVHD,      1'b0, '0},
    '{1'b0, 3'd4, 32'h00000000,   1'b0, '0},
    '{1'b0, 3'd4, 32'hFFFFFFFF,   1'b0, '0},
    '{1'b0, 3'd3, 32'h00ABCDEF,   1'b0, '0},
    // moov payload ends halfway through a child header
    '{1'b0, 3'd4, 32'd12,         1'b0, '0},
    '{1'b0, 3'd4, KIND_MOOV,      1'b0, '0},
    '{1'b0, 3'd4, 32'h00000010,   1'b0, '0},
    // parse is back at top level: size 7 is an error
    '{1'b0, 3'd4, 32'd7,          1'b0, '0},
    '{1'b0, 3'd4, KIND_MVHD,      1'b1, '{RES_ERROR, 32'd0, 32'd0}},
    // new file whose box runs past the end of the stream
    '{1'b1, 3'd4, 32'h00001000,   1'b0, '0},
    '{1'b0, 3'd4, KIND_FREE,      1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        start_of_file;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [31:0] created_seconds;
  logic [31:0] modified_seconds;

  mp4_movie_header_time_extractor u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .start_of_file    (start_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .created_seconds  (created_seconds),
    .modified_seconds (modified_seconds)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Parser shadow state, advanced once per accepted input beat.
  walk_phase_e walk_phase;
  logic [2:0]  hdr_cnt;
  logic [31:0] box_len;
  logic [31:0] box_type;   // doubles as modification-time shifter in mvhd
  logic [31:0] box_left;
  logic [31:0] moov_left;
  logic        in_moov;
  logic [31:0] created_acc;
  logic        parse_halted;

  result_t     times_due [$];   // results still owed by the block, in order
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          results_planned = 0;
  bit          steady = 1'b0;   // both sides run gap-free for this file
  bit          hold_req = 1'b0;

  logic [7:0]  file_q [$];
  logic [7:0]  kid_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic clear_parser();
    walk_phase   = WALK_HEADER;
    hdr_cnt      = '0;
    box_len      = '0;
    box_type     = '0;
    box_left     = '0;
    moov_left    = '0;
    in_moov      = 1'b0;
    created_acc  = '0;
    parse_halted = 1'b0;
  endtask

  // One byte through the shadow parser; got says whether it completes a beat.
  task automatic track_byte(input logic [7:0] b, input logic sof,
                            output bit got, output result_t res);
    logic [31:0] payload;
    logic [31:0] off;
    got = 1'b0;
    res = '0;
    if (sof) clear_parser();
    if (parse_halted) return;

    if (in_moov) moov_left = moov_left - 32'd1;

    if (walk_phase == WALK_HEADER) begin
      if (hdr_cnt < 3'd4) box_len = {box_len[23:0], b};
      else box_type = {box_type[23:0], b};
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt == 3'd0) begin
        if (box_len < HDR_LEN) begin
          // malformed size: report once, then go deaf until next file
          parse_halted = 1'b1;
          walk_phase   = WALK_HEADER;
          got          = 1'b1;
          res.kind     = RES_ERROR;
        end else begin
          payload    = box_len - HDR_LEN;
          walk_phase = WALK_HEADER;
          if (!in_moov && box_type == KIND_MOOV) begin
            if (payload != 0) begin
              in_moov   = 1'b1;
              moov_left = payload;
            end
          end else if (in_moov && box_type == KIND_MVHD && payload >= 32'd12) begin
            walk_phase  = WALK_MVHD;
            box_left    = payload;
            created_acc = '0;
            box_type    = '0;
          end else if (payload != 0) begin
            walk_phase = WALK_SKIP;
            box_left   = payload;
          end
        end
      end
    end else begin
      if (walk_phase == WALK_MVHD) begin
        // offsets 4..7 creation, 8..11 modification
        off = (box_len - HDR_LEN) - box_left;
        if (off >= 32'd4 && off < 32'd8) created_acc = {created_acc[23:0], b};
        else if (off >= 32'd8 && off < 32'd12) box_type = {box_type[23:0], b};
        if (off == 32'd11) begin
          got          = 1'b1;
          res.kind     = RES_TIMES;
          res.created  = created_acc - EPOCH_SHIFT;
          res.modified = box_type - EPOCH_SHIFT;
        end
      end
      box_left = box_left - 32'd1;
      if (box_left == 0) walk_phase = WALK_HEADER;
    end

    // moov payload used up: drop any partial child, back to top level
    if (!parse_halted && in_moov && moov_left == 0) begin
      in_moov    = 1'b0;
      walk_phase = WALK_HEADER;
      hdr_cnt    = '0;
      box_left   = '0;
      box_len    = '0;
    end
  endtask

  // Offer one byte, wait for the beat, then book what it should produce.
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic sof,
                           input bit typed, input result_t want);
    int      gap;
    bit      got;
    result_t res;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    do @(posedge clk); while (!in_ready);
    track_byte(b, sof, got, res);
    if (typed) begin
      times_due.push_back(want);
      results_planned++;
    end else if (got) begin
      times_due.push_back(res);
      results_planned++;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic put_word(ref logic [7:0] q [$], input logic [31:0] w);
    for (int k = 3; k >= 0; k--) q.push_back(w[8*k +: 8]);
  endtask

  task automatic put_noise(ref logic [7:0] q [$], input int n);
    for (int k = 0; k < n; k++) q.push_back(8'($urandom));
  endtask

  // Times clustered around the epoch offset and the 32-bit ends.
  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(0, 7))
      0:       return EPOCH_SHIFT;
      1:       return EPOCH_SHIFT - 32'd1;
      2:       return 32'd0;
      3:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // One child box of a moov into kid_q.
  task automatic add_child(input bit times_only);
    logic [7:0] body [$];
    int         pick;
    int         p;
    pick = times_only ? 0 : $urandom_range(0, 99);
    if (pick < 65) begin
      if (!times_only && $urandom_range(0, 6) == 0) p = $urandom_range(0, 11);
      else p = $urandom_range(12, 20);
      put_word(body, $urandom);
      put_word(body, pick_stamp());
      put_word(body, pick_stamp());
      put_noise(body, 8);
      put_word(kid_q, p + 8);
      put_word(kid_q, KIND_MVHD);
      for (int k = 0; k < p; k++) kid_q.push_back(body[k]);
    end else if (pick < 85) begin
      p = $urandom_range(0, 6);
      put_word(kid_q, p + 8);
      put_word(kid_q, $urandom_range(0, 1) ? KIND_FREE : 32'($urandom));
      put_noise(kid_q, p);
    end else if (pick < 95) begin
      // nested moov is skipped like any other child
      p = $urandom_range(0, 6);
      put_word(kid_q, p + 8);
      put_word(kid_q, KIND_MOOV);
      put_noise(kid_q, p);
    end else begin
      put_word(kid_q, $urandom_range(0, 7));
      put_word(kid_q, $urandom);
      put_noise(kid_q, $urandom_range(0, 4));
    end
  endtask

  task automatic add_moov(input bit times_only);
    int nk;
    int plen;
    kid_q.delete();
    nk = times_only ? 1 : $urandom_range(0, 3);
    repeat (nk) add_child(times_only);
    plen = kid_q.size();
    // now and then the moov size undercounts its children
    if (!times_only && plen > 0 && $urandom_range(0, 6) == 0)
      plen -= $urandom_range(1, plen < 6 ? plen : 6);
    put_word(file_q, plen + 8);
    put_word(file_q, KIND_MOOV);
    foreach (kid_q[k]) file_q.push_back(kid_q[k]);
  endtask

  // Mostly well-formed files; the rest is errors, truncation and noise.
  task automatic build_file(input bit dense);
    int nboxes;
    int pick;
    int n;
    file_q.delete();
    nboxes = $urandom_range(1, 4);
    for (int i = 0; i < nboxes; i++) begin
      pick = dense ? 0 : $urandom_range(0, 99);
      if (pick < 60) begin
        add_moov(dense);
      end else if (pick < 78) begin
        n = $urandom_range(0, 8);
        put_word(file_q, n + 8);
        case ($urandom_range(0, 2))
          0:       put_word(file_q, KIND_FREE);
          1:       put_word(file_q, KIND_MVHD);
          default: put_word(file_q, $urandom);
        endcase
        put_noise(file_q, n);
      end else if (pick < 88) begin
        put_word(file_q, $urandom_range(0, 7));
        put_word(file_q, $urandom);
        put_noise(file_q, $urandom_range(0, 6));
      end else if (pick < 94) begin
        // any size at all, so the file usually ends inside the box
        put_word(file_q, $urandom);
        put_word(file_q, $urandom);
        put_noise(file_q, $urandom_range(0, 10));
        break;
      end else begin
        put_noise(file_q, $urandom_range(1, 12));
      end
    end
  endtask

  // Receiver: per beat a random hold-off, plus one long one on request.
  initial begin
    int hold;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Output check: every beat against the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (times_due.size() == 0) begin
        report_mismatch("beat with nothing owed, created", created_seconds, 32'd0);
      end else begin
        want = times_due.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
        if (created_seconds !== want.created)
          report_mismatch("created_seconds", created_seconds, want.created);
        if (modified_seconds !== want.modified)
          report_mismatch("modified_seconds", modified_seconds, want.modified);
      end
    end
  end

  // Hang detector: cycles without a beat on either channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_mp4_movie_header_time_extractor NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  file_no;
    bit  dense;
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    start_of_file = 1'b0;
    rst           = 1'b1;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = int'(PLAN[r].nbytes) - 1; k >= 0; k--) begin
        send_byte(PLAN[r].word[8*k +: 8],
                  PLAN[r].sof && k == int'(PLAN[r].nbytes) - 1,
                  PLAN[r].typed && k == 0, PLAN[r].want);
      end
    end

    // random files
    file_no = 0;
    while (bytes_sent < BYTE_GOAL || results_planned < TIMES_GOAL) begin
      dense = file_no >= HOLD_FILE && file_no < HOLD_FILE + HOLD_SPAN;
      build_file(dense);
      steady = dense || $urandom_range(0, 4) == 0;
      if (file_no == HOLD_FILE) hold_req = 1'b1;
      foreach (file_q[i]) begin
        send_byte(file_q[i],
                  i == 0 && (file_no == 0 || $urandom_range(0, 19) != 0),
                  1'b0, '0);
      end
      file_no++;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // drain, then let anything stray arrive
    while (times_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_mp4_movie_header_time_extractor OK");
    end else begin
      $display("tb_mp4_movie_header_time_extractor NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/mtx_pkg.sv
design/mtx_parser.sv
design/mp4_movie_header_time_extractor.sv
tb/tb_mp4_movie_header_time_extractor.sv
